/* rtl/bsm_pkg.sv */
// Shared types and constants for the bank switch mapper.
package bsm_pkg;

   typedef enum logic [2:0] {
      OP_CPU_WRITE = 3'd0,
      OP_CPU_READ  = 3'd1,
      OP_PPU_READ  = 3'd2,
      OP_PPU_WRITE = 3'd3,
      OP_TICK      = 3'd4
   } opcode_type;

   localparam logic [1:0] TGT_NONE = 2'd0;
   localparam logic [1:0] TGT_PRAM = 2'd1;
   localparam logic [1:0] TGT_PROM = 2'd2;
   localparam logic [1:0] TGT_CHR  = 2'd3;

   localparam logic [2:0] CSR_PRG_COUNT  = 3'd0;
   localparam logic [2:0] CSR_CHR_COUNT  = 3'd1;
   localparam logic [2:0] CSR_CHR_IS_RAM = 3'd2;
   localparam logic [2:0] CSR_PRAM_PRES  = 3'd3;
   localparam logic [2:0] CSR_MIRROR_RST = 3'd4;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [15:0] address;
      logic [7:0]  write_data;
   } req_type;

   typedef struct packed {
      logic [18:0] mapped_address;
      logic [1:0]  target;
      logic        memory_write;
      logic        read_zero;
      logic        irq_line;
      logic        mirror_mode;
   } rsp_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;   // capture the request and do the register update
      logic step;   // one step of the bank modulo reduction
      logic finish; // form the result
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic mod_done;
   } status_type;

endpackage

/* rtl/bsm_datapath.sv */
// Datapath of the bank switch mapper: mapper state, bank select and modulo unit.
module bsm_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [2:0]          csr_index,
   input  logic [8:0]          csr_write_data,
   input  bsm_pkg::req_type    req_payload,
   input  bsm_pkg::cmd_type    cmd,
   output bsm_pkg::status_type status,
   output bsm_pkg::rsp_type    rsp_result
);
   import bsm_pkg::*;

   logic [6:0]  prg_count_ff;
   logic [8:0]  chr_count_ff;
   logic        chr_is_ram_ff, pram_present_ff, mirror_rst_ff;
   logic [2:0]  select_ff;
   logic [7:0]  bank_ff [8];
   logic        chr_layout_ff, prg_layout_ff;
   logic [7:0]  latch_ff, counter_ff;
   logic        irq_en_ff, reload_ff, irq_ff, mirror_ff, mirror_written_ff;

   req_type     req_ff;
   logic [8:0]  rem_ff, rem_in;   // bank being reduced
   logic [8:0]  div_ff;           // effective bank count
   logic [1:0]  kind_ff;          // target memory of the item in work
   rsp_type     out_ff, out_in;

   logic [8:0]  rem_load, div_load;
   logic [1:0]  kind_load;

   // Effective counts.
   logic [6:0] prg_total;
   logic [8:0] chr_total;
   always_comb begin
      if (prg_count_ff == 7'd0) prg_total = 7'd1;
      else if (prg_count_ff > 7'd64) prg_total = 7'd64;
      else prg_total = prg_count_ff;
      chr_total = (chr_count_ff == 9'd0) ? 9'd1 : chr_count_ff;
   end

   // Bank chosen for the incoming request (before reduction).
   logic [1:0] pslot;
   logic [2:0] cslot;
   logic [8:0] pbank, cbank, second_last;
   always_comb begin
      pslot = req_payload.address[14:13];
      second_last = {1'b0, prg_total, 1'b0} - 9'd2;
      case (pslot)
         2'd0: pbank = prg_layout_ff ? second_last : {1'b0, bank_ff[6]};
         2'd1: pbank = {1'b0, bank_ff[7]};
         2'd2: pbank = prg_layout_ff ? {1'b0, bank_ff[6]} : second_last;
         default: pbank = {2'b0, prg_total} - 9'd1;
      endcase
      cslot = req_payload.address[12:10] ^ {chr_layout_ff, 2'b00};
      if (!cslot[2])
         cbank = {1'b0, bank_ff[{2'b00, cslot[1]}] & 8'hFE} + {8'd0, cslot[0]};
      else
         cbank = {1'b0, bank_ff[cslot - 3'd2]};
   end

   // Iterative reduction: subtract the count while the value is at least it.
   assign status.mod_done = rem_ff < div_ff;
   assign rem_in = status.mod_done ? rem_ff : rem_ff - div_ff;

   logic odd;
   assign odd = req_payload.address[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_count_ff <= 7'd32; chr_count_ff <= 9'd128;
         chr_is_ram_ff <= 1'b0; pram_present_ff <= 1'b1; mirror_rst_ff <= 1'b0;
         select_ff <= '0; chr_layout_ff <= 1'b0; prg_layout_ff <= 1'b0;
         for (int i = 0; i < 8; i++) bank_ff[i] <= '0;
         latch_ff <= '0; counter_ff <= '0; irq_en_ff <= 1'b0; reload_ff <= 1'b0;
         irq_ff <= 1'b0; mirror_ff <= 1'b0; mirror_written_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_PRG_COUNT:  prg_count_ff <= csr_write_data[6:0];
               CSR_CHR_COUNT:  chr_count_ff <= csr_write_data;
               CSR_CHR_IS_RAM: chr_is_ram_ff <= csr_write_data[0];
               CSR_PRAM_PRES:  pram_present_ff <= csr_write_data[0];
               CSR_MIRROR_RST: begin
                  mirror_rst_ff <= csr_write_data[0];
                  if (!mirror_written_ff) mirror_ff <= csr_write_data[0];
               end
               default: ;
            endcase
         end
         if (cmd.load) begin
            if (req_payload.opcode == OP_CPU_WRITE && req_payload.address[15]) begin
               case (req_payload.address[14:13])
                  2'd0: begin
                     if (odd)
                        bank_ff[select_ff] <= (select_ff >= 3'd6) ?
                           (req_payload.write_data & 8'h3F) : req_payload.write_data;
                     else begin
                        select_ff <= req_payload.write_data[2:0];
                        prg_layout_ff <= req_payload.write_data[6];
                        chr_layout_ff <= req_payload.write_data[7];
                     end
                  end
                  2'd1: begin
                     if (!odd) begin
                        mirror_ff <= ~req_payload.write_data[0];
                        mirror_written_ff <= 1'b1;
                     end
                  end
                  2'd2: begin
                     if (odd) reload_ff <= 1'b1;
                     else latch_ff <= req_payload.write_data;
                  end
                  default: begin
                     if (odd) irq_en_ff <= 1'b1;
                     else begin
                        irq_en_ff <= 1'b0;
                        irq_ff <= 1'b0;
                     end
                  end
               endcase
            end else if (req_payload.opcode == OP_TICK) begin
               if (counter_ff == 8'd0 || reload_ff) begin
                  counter_ff <= latch_ff;
                  reload_ff <= 1'b0;
                  if (latch_ff == 8'd0 && irq_en_ff) irq_ff <= 1'b1;
               end else begin
                  counter_ff <= counter_ff - 8'd1;
                  if (counter_ff == 8'd1 && irq_en_ff) irq_ff <= 1'b1;
               end
            end
         end
      end
   end

   // Target, starting bank and divisor of the incoming request.
   always_comb begin
      kind_load = TGT_NONE;
      rem_load  = '0;
      div_load  = 9'd1;
      case (req_payload.opcode)
         OP_CPU_WRITE, OP_CPU_READ: begin
            if (req_payload.address[15:13] == 3'b011) kind_load = TGT_PRAM;
            else if (req_payload.address[15] &&
                     req_payload.opcode == OP_CPU_READ) begin
               kind_load = TGT_PROM;
               rem_load  = pbank;
               div_load  = {2'b0, prg_total};
            end
         end
         OP_PPU_READ, OP_PPU_WRITE: begin
            kind_load = TGT_CHR;
            rem_load  = cbank;
            div_load  = chr_total;
         end
         default: ;
      endcase
   end

   // Result of the item in work, taken once the reduction is done.
   always_comb begin
      out_in = '0;
      out_in.irq_line = irq_ff;
      out_in.mirror_mode = mirror_ff;
      out_in.target = kind_ff;
      case (kind_ff)
         TGT_PRAM: begin
            out_in.mapped_address = {6'd0, req_ff.address[12:0]};
            out_in.memory_write = (req_ff.opcode == OP_CPU_WRITE) && pram_present_ff;
            out_in.read_zero = (req_ff.opcode == OP_CPU_READ) && !pram_present_ff;
         end
         TGT_PROM: begin
            out_in.mapped_address = {rem_ff[5:0], req_ff.address[12:0]};
         end
         TGT_CHR: begin
            out_in.mapped_address = {rem_ff, req_ff.address[9:0]};
            out_in.memory_write = (req_ff.opcode == OP_PPU_WRITE) && chr_is_ram_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_payload;
         kind_ff <= kind_load;
         rem_ff <= rem_load;
         div_ff <= div_load;
      end else if (cmd.step) begin
         rem_ff <= rem_in;
      end
      if (cmd.finish) out_ff <= out_in;
   end

   assign rsp_result = out_ff;

endmodule

/* rtl/bsm_control.sv */
// Controller state machine of the bank switch mapper.
module bsm_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  bsm_pkg::status_type status,
   output bsm_pkg::cmd_type    cmd
);
   import bsm_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_REDUCE, S_FINISH, S_HOLD} state_type;
   state_type state_ff;
   logic      valid_ff;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;

   always_comb begin
      cmd.load   = (state_ff == S_IDLE) && req_valid;
      cmd.step   = (state_ff == S_REDUCE) && !status.mod_done;
      cmd.finish = (state_ff == S_FINISH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE:   if (req_valid) state_ff <= S_REDUCE;
            S_REDUCE: if (status.mod_done) state_ff <= S_FINISH;
            S_FINISH: begin
               valid_ff <= 1'b1;
               state_ff <= S_HOLD;
            end
            S_HOLD: begin
               if (!rsp_stall) begin
                  valid_ff <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == S_HOLD)
      else $error("result shown outside hold state");
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !cmd.load)
      else $error("second item loaded while busy");
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid)
      else $error("finish did not raise valid");

endmodule

/* rtl/bank_switch_mapper_with_scanline_irq.sv */
// Top level of the bank switch mapper with scanline interrupt counter.
// The request is registered on acceptance; the reduction then subtracts the bank count
// from the bank until it is below the count, and the result is registered and offered
// until it is taken. One item is in work at a time; the next is accepted after that.
// Synchronous active-high reset restores the controller, mapper state and configuration
// registers to power-up values, but not the request, reduction and result registers;
// until the CPU writes mirroring, a CSR write to mirroring_at_reset also sets mirroring.
module bank_switch_mapper_with_scanline_irq (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bsm_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bsm_pkg::rsp_type rsp_payload,
   input  logic             csr_write_enable,
   input  logic [2:0]       csr_index,
   input  logic [8:0]       csr_write_data
);
   import bsm_pkg::*;

   cmd_type    cmd;
   status_type status;

   // The controller sequences one transfer at a time.
   bsm_control u_control (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .status, .cmd
   );

   // The datapath holds mapper state and forms the result.
   bsm_datapath u_datapath (
      .clock, .reset, .csr_write_enable, .csr_index, .csr_write_data,
      .req_payload, .cmd, .status, .rsp_result(rsp_payload)
   );

endmodule
